[rtl/core/amse_pkg.sv]
// Shared types, constants and defaults for the angle median speed estimator.
`default_nettype none
package amse_pkg;

	localparam int SENSORS_DEF = 4;
	localparam int WINDOW_DEF  = 10;

	localparam int SENSOR_W = 2;
	localparam int ANGLE_W  = 12;
	localparam int SPEED_W  = 12;
	localparam int DIFF_W   = 13;
	localparam int MAG_W    = 11;
	localparam int MAG5_W   = 14;
	localparam int PROD_W   = 28;

	localparam int HALF_TURN = 1800;
	localparam int FULL_TURN = 3600;

	// x / 6 == (x * 10923) >> 16 for 0 <= x <= 9000
	localparam int RECIP_6  = 10923;
	localparam int RECIP_SH = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DIFF,
		ST_SCALE,
		ST_MULT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic scan;
		logic capture;
		logic diff;
		logic scale;
		logic mult;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic win_done;
		logic load_done;
		logic hit;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

[rtl/core/angle_median_speed_estimator.sv]
// A sample that does not close a window is taken without a stall; a closing sample has
// its word in the output register after one RAM read per window entry, then one
// pipelined rank check per candidate, then unwrap and 5/6 scaling in the DIFF, SCALE,
// MULT and EMIT states. Input is stalled from the closing sample until its word
// leaves the speed pipeline. Reset (arst_n low) clears fill counts, last medians and
// control state at once; window RAM needs no clearing.
`default_nettype none
module angle_median_speed_estimator #(
	parameter int SENSORS = amse_pkg::SENSORS_DEF,
	parameter int WINDOW  = amse_pkg::WINDOW_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [amse_pkg::SENSOR_W-1:0] sensor_index,
	input  wire logic                                 sample_valid,
	input  wire logic        [amse_pkg::ANGLE_W-1:0]  angle,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic             [amse_pkg::SENSOR_W-1:0] out_sensor,
	output logic             [amse_pkg::ANGLE_W-1:0]  median_angle,
	output logic signed      [amse_pkg::SPEED_W-1:0]  speed_rpm
);

	amse_pkg::dp_cmd_t    cmd;
	amse_pkg::dp_status_t status;

	amse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	amse_dp #(
		.SENSORS(SENSORS),
		.WINDOW (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sensor_index(sensor_index),
		.sample_valid(sample_valid),
		.angle       (angle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_sensor  (out_sensor),
		.median_angle(median_angle),
		.speed_rpm   (speed_rpm)
	);

	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && status.win_done) |=> (in_stall && cmd.load))
		else $error("closing sample did not start window load");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load, cmd.scan, cmd.diff, cmd.scale, cmd.mult,
			cmd.emit}))
		else $error("more than one datapath command active");

	a_load_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		status.load_done |=> cmd.scan)
		else $error("scan did not follow window load");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit))
		else $error("output word appeared without emit");

endmodule
`default_nettype wire

[rtl/core/amse_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module amse_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 40,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/amse_ctrl.sv]
// Sequencing state machine: accept, window load, median scan, speed arithmetic, emit.
`default_nettype none
module amse_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire amse_pkg::dp_status_t status,
	output amse_pkg::dp_cmd_t        cmd
);

	amse_pkg::state_t state_q;
	amse_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amse_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			amse_pkg::ST_IDLE: begin
				if (in_valid && status.win_done) begin
					state_nxt = amse_pkg::ST_LOAD;
				end
			end
			amse_pkg::ST_LOAD: begin
				if (status.load_done) begin
					state_nxt = amse_pkg::ST_SCAN;
				end
			end
			amse_pkg::ST_SCAN: begin
				if (status.hit) begin
					state_nxt = amse_pkg::ST_DIFF;
				end
			end
			amse_pkg::ST_DIFF:  state_nxt = amse_pkg::ST_SCALE;
			amse_pkg::ST_SCALE: state_nxt = amse_pkg::ST_MULT;
			amse_pkg::ST_MULT:  state_nxt = amse_pkg::ST_EMIT;
			amse_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_nxt = amse_pkg::ST_IDLE;
				end
			end
			default: state_nxt = amse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			amse_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			amse_pkg::ST_LOAD: cmd.load = 1'b1;
			amse_pkg::ST_SCAN: begin
				cmd.scan    = 1'b1;
				cmd.capture = status.hit;
			end
			amse_pkg::ST_DIFF:  cmd.diff  = 1'b1;
			amse_pkg::ST_SCALE: cmd.scale = 1'b1;
			amse_pkg::ST_MULT:  cmd.mult  = 1'b1;
			amse_pkg::ST_EMIT:  cmd.emit  = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/amse_dp.sv]
// Datapath: window storage, fill counters, median rank scan, unwrap and speed scaling.
`default_nettype none
module amse_dp #(
	parameter int SENSORS = amse_pkg::SENSORS_DEF,
	parameter int WINDOW  = amse_pkg::WINDOW_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire amse_pkg::dp_cmd_t                     cmd,
	output amse_pkg::dp_status_t                       status,
	input  wire logic        [amse_pkg::SENSOR_W-1:0]  sensor_index,
	input  wire logic                                  sample_valid,
	input  wire logic        [amse_pkg::ANGLE_W-1:0]   angle,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic             [amse_pkg::SENSOR_W-1:0]  out_sensor,
	output logic             [amse_pkg::ANGLE_W-1:0]   median_angle,
	output logic signed      [amse_pkg::SPEED_W-1:0]   speed_rpm
);

	localparam int DEPTH  = SENSORS * WINDOW;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SEN_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int AW_ = amse_pkg::ANGLE_W;

	logic [FILL_W-1:0] fill_q [SENSORS];
	logic [AW_-1:0]    last_q [SENSORS];
	logic [FILL_W-1:0] ld_cnt_q;
	logic [amse_pkg::SENSOR_W-1:0] sensor_q;
	logic [AW_-1:0]    win_q [WINDOW];

	logic [WINDOW-1:0] lt_s1;
	logic [WINDOW-1:0] gt_s1;
	logic [AW_-1:0]    cand_s1;
	logic              vld_s1;

	logic [AW_-1:0]    med_q;
	logic signed [amse_pkg::SPEED_W-1:0] diff_q;
	logic              neg_q;
	logic [amse_pkg::MAG5_W-1:0] mag5_q;
	logic [amse_pkg::PROD_W-1:0] prod_q;

	logic [SEN_W-1:0]  in_idx;
	logic [SEN_W-1:0]  cur_idx;
	logic              sample_ok;
	logic              win_last;
	logic              ld_busy;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [AW_-1:0]    rdata;
	logic [CNT_W-1:0]  below;
	logic [CNT_W-1:0]  above;
	logic signed [amse_pkg::DIFF_W-1:0] diff_raw;
	logic signed [amse_pkg::DIFF_W-1:0] diff_wrap;
	logic [amse_pkg::MAG_W-1:0]  mag;
	logic [amse_pkg::SPEED_W-1:0] quo;

	assign in_idx    = SEN_W'(sensor_index);
	assign cur_idx   = SEN_W'(sensor_q);
	assign sample_ok = sample_valid && (int'(sensor_index) < SENSORS);
	assign win_last  = sample_ok && (fill_q[in_idx] == FILL_W'(WINDOW - 1));
	assign ld_busy   = (ld_cnt_q != FILL_W'(WINDOW));

	assign waddr = AW'(int'(in_idx) * WINDOW + int'(fill_q[in_idx]));
	assign raddr = AW'(int'(cur_idx) * WINDOW + int'(ld_cnt_q));

	amse_ram #(
		.WIDTH(AW_),
		.DEPTH(DEPTH)
	) u_win_ram (
		.clk  (clk),
		.we   (cmd.accept && sample_ok),
		.waddr(waddr),
		.wdata(angle),
		.re   (cmd.load && ld_busy),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSORS; i++) begin
				fill_q[i] <= '0;
				last_q[i] <= '0;
			end
			ld_cnt_q  <= '0;
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.accept && sample_ok) begin
				fill_q[in_idx] <= win_last ? '0 : fill_q[in_idx] + 1'b1;
			end
			if (cmd.load) begin
				ld_cnt_q <= ld_busy ? ld_cnt_q + 1'b1 : '0;
			end
			if (cmd.diff) begin
				last_q[cur_idx] <= med_q;
			end
			vld_s1 <= cmd.scan;
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// shift in the window on load, rotate candidates on scan; also the rank, median and speed registers
	always_ff @(posedge clk) begin
		if (cmd.accept && sample_ok) begin
			sensor_q <= sensor_index;
		end
		if (cmd.load && (ld_cnt_q != '0)) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WINDOW - 1] <= rdata;
		end else if (cmd.scan) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WINDOW - 1] <= win_q[0];
		end
		if (cmd.scan) begin
			for (int i = 0; i < WINDOW; i++) begin
				lt_s1[i] <= win_q[i] < win_q[0];
				gt_s1[i] <= win_q[i] > win_q[0];
			end
			cand_s1 <= win_q[0];
		end
		if (cmd.capture) begin
			med_q <= cand_s1;
		end
		if (cmd.diff) begin
			diff_q <= diff_wrap[amse_pkg::SPEED_W-1:0];
		end
		if (cmd.scale) begin
			neg_q  <= diff_q[amse_pkg::SPEED_W-1];
			mag5_q <= {1'b0, mag, 2'b00} + amse_pkg::MAG5_W'(mag);
		end
		if (cmd.mult) begin
			prod_q <= amse_pkg::PROD_W'(mag5_q) * amse_pkg::PROD_W'(amse_pkg::RECIP_6);
		end
		if (cmd.emit) begin
			out_sensor   <= sensor_q;
			median_angle <= med_q;
			speed_rpm    <= neg_q ? -quo : quo;
		end
	end

	always_comb begin
		below = '0;
		above = '0;
		for (int i = 0; i < WINDOW; i++) begin
			below = below + CNT_W'(lt_s1[i]);
			above = above + CNT_W'(gt_s1[i]);
		end
	end

	always_comb begin
		diff_raw = $signed({1'b0, med_q}) - $signed({1'b0, last_q[cur_idx]});
		if (diff_raw < -amse_pkg::DIFF_W'(amse_pkg::HALF_TURN)) begin
			diff_wrap = diff_raw + amse_pkg::DIFF_W'(amse_pkg::FULL_TURN);
		end else if (diff_raw > amse_pkg::DIFF_W'(amse_pkg::HALF_TURN)) begin
			diff_wrap = diff_raw - amse_pkg::DIFF_W'(amse_pkg::FULL_TURN);
		end else begin
			diff_wrap = diff_raw;
		end
	end

	assign mag = diff_q[amse_pkg::SPEED_W-1] ? amse_pkg::MAG_W'(-diff_q)
		: amse_pkg::MAG_W'(diff_q);
	assign quo = prod_q[amse_pkg::RECIP_SH +: amse_pkg::SPEED_W];

	assign status.win_done  = win_last;
	assign status.load_done = cmd.load && !ld_busy;
	assign status.hit       = vld_s1 && (below <= CNT_W'(WINDOW / 2))
		&& (above <= CNT_W'(WINDOW / 2));
	assign status.out_free  = !out_valid || !out_stall;

endmodule
`default_nettype wire

[verif/tb_angle_median_speed_estimator.sv]
`timescale 1ns / 1ps
// Testbench for the angle median speed estimator: directed and random samples, scoreboard, stalls.
module tb_angle_median_speed_estimator;

	localparam int SENSORS     = amse_pkg::SENSORS_DEF;
	localparam int WIN         = amse_pkg::WINDOW_DEF;
	localparam int SENSOR_W    = amse_pkg::SENSOR_W;
	localparam int ANGLE_W     = amse_pkg::ANGLE_W;
	localparam int SPEED_W     = amse_pkg::SPEED_W;
	localparam int HALF_TURN   = amse_pkg::HALF_TURN;
	localparam int FULL_TURN   = amse_pkg::FULL_TURN;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int NUM_ITEMS   = 450;

	typedef struct packed {
		logic [SENSOR_W-1:0]       sensor;
		logic [ANGLE_W-1:0]        median;
		logic signed [SPEED_W-1:0] speed;
	} speed_word_t;

	class median_speed_scoreboard;
		logic [ANGLE_W-1:0] window [SENSORS][WIN];
		int unsigned        fill [SENSORS];
		logic [ANGLE_W-1:0] last_median [SENSORS];
		speed_word_t        pending [$];
		int unsigned        mismatches;

		function new();
			foreach (fill[i]) begin
				fill[i] = 0;
				last_median[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void note_sample(logic [SENSOR_W-1:0] s, logic ok, logic [ANGLE_W-1:0] ang);
			int unsigned below, above;
			logic [ANGLE_W-1:0] med;
			int d;
			bit found;
			speed_word_t w;
			if (!ok || s >= SENSORS)
				return;
			if (fill[s] >= WIN)
				fill[s] = 0;
			window[s][fill[s]] = ang;
			fill[s]++;
			if (fill[s] < WIN)
				return;
			fill[s] = 0;
			found = 1'b0;
			med = window[s][0];
			for (int p = 0; p < WIN; p++) begin
				if (!found) begin
					below = 0;
					above = 0;
					for (int q = 0; q < WIN; q++) begin
						if (window[s][q] < window[s][p])
							below++;
						else if (window[s][q] > window[s][p])
							above++;
					end
					if (below <= WIN / 2 && above <= WIN / 2) begin
						med = window[s][p];
						found = 1'b1;
					end
				end
			end
			d = int'(med) - int'(last_median[s]);
			if (d < -HALF_TURN)
				d += FULL_TURN;
			else if (d > HALF_TURN)
				d -= FULL_TURN;
			last_median[s] = med;
			d = (d * 5) / 6;
			w.sensor = s;
			w.median = med;
			w.speed = d[SPEED_W-1:0];
			pending.push_back(w);
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d, expected %0d", what, got, want);
			mismatches++;
		endtask

		task check_word(logic [SENSOR_W-1:0] s, logic [ANGLE_W-1:0] m,
			logic signed [SPEED_W-1:0] v);
			speed_word_t want;
			if (pending.size() == 0) begin
				report("unexpected word, median", int'(m), 0);
				return;
			end
			want = pending.pop_front();
			if (s !== want.sensor)
				report("out_sensor", int'(s), int'(want.sensor));
			if (m !== want.median)
				report("median_angle", int'(m), int'(want.median));
			if (v !== want.speed)
				report("speed_rpm", int'(v), int'(want.speed));
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [SENSOR_W-1:0]        sensor_index = '0;
	logic                       sample_valid = 1'b0;
	logic [ANGLE_W-1:0]         angle = '0;
	logic                       out_valid;
	logic                       out_stall;
	logic [SENSOR_W-1:0]        out_sensor;
	logic [ANGLE_W-1:0]         median_angle;
	logic signed [SPEED_W-1:0]  speed_rpm;

	logic                       rx_stall = 1'b1;
	logic                       hold_off = 1'b0;
	int unsigned                items_sent = 0;
	int unsigned                samples_sent = 0;
	int unsigned                words_taken = 0;
	logic [ANGLE_W-1:0]         drift_base [SENSORS];
	logic [ANGLE_W-1:0]         prev_angle [SENSORS];

	median_speed_scoreboard sb = new();

	assign out_stall = rx_stall | hold_off;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	angle_median_speed_estimator #(
		.SENSORS(SENSORS),
		.WINDOW (WIN)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sensor_index(sensor_index),
		.sample_valid(sample_valid),
		.angle       (angle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_sensor  (out_sensor),
		.median_angle(median_angle),
		.speed_rpm   (speed_rpm)
	);

	task automatic send_sample(input logic [SENSOR_W-1:0] s, input logic ok,
		input logic [ANGLE_W-1:0] ang);
		int unsigned gap;
		gap = ((items_sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensor_index = s;
		sample_valid = ok;
		angle = ang;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s, ok, ang);
		items_sent++;
		if (ok)
			samples_sent++;
		prev_angle[s] = ang;
		@(negedge clk);
	endtask

	task automatic send_random_sample();
		int unsigned r;
		logic [SENSOR_W-1:0] s;
		logic [ANGLE_W-1:0] ang;
		r = $urandom_range(0, 99);
		s = SENSOR_W'($urandom_range(0, SENSORS - 1));
		drift_base[s] = ANGLE_W'((int'(drift_base[s]) + FULL_TURN
			+ int'($urandom_range(0, 120)) - 40) % FULL_TURN);
		if (r < 8) begin
			ang = ANGLE_W'($urandom);
			send_sample(s, 1'b0, ang);
		end else begin
			if (r < 16)
				ang = ANGLE_W'($urandom);
			else if (r < 24)
				ang = prev_angle[s];
			else if (r < 30)
				ang = ($urandom_range(0, 1) != 0) ? ANGLE_W'($urandom_range(0, 30))
					: ANGLE_W'($urandom_range(FULL_TURN - 30, FULL_TURN - 1));
			else
				ang = ANGLE_W'((int'(drift_base[s]) + FULL_TURN
					+ int'($urandom_range(0, 100)) - 50) % FULL_TURN);
			send_sample(s, 1'b1, ang);
		end
	endtask

	initial begin
		foreach (drift_base[i]) begin
			drift_base[i] = ANGLE_W'($urandom_range(0, FULL_TURN - 1));
			prev_angle[i] = '0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_sample(2'd3, 1'b0, 12'd4095);
		send_sample(2'd0, 1'b1, 12'd0);
		send_sample(2'd0, 1'b1, 12'd4095);
		send_sample(2'd2, 1'b0, 12'd0);
		send_sample(2'd0, 1'b1, 12'd3599);
		send_sample(2'd0, 1'b1, 12'd1);
		send_sample(2'd0, 1'b1, 12'd2048);
		send_sample(2'd0, 1'b1, 12'd2048);
		send_sample(2'd0, 1'b1, 12'd2048);
		send_sample(2'd0, 1'b1, 12'd0);
		send_sample(2'd0, 1'b1, 12'd4095);
		send_sample(2'd0, 1'b1, 12'd1800);
		repeat (WIN) send_sample(2'd1, 1'b1, 12'd3599);

		while (items_sent < NUM_ITEMS)
			send_random_sample();
		in_valid = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * WIN + 10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned gap;
		wait (arst_n);
		forever begin
			gap = ((words_taken / 12) % 3 == 2) ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				rx_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			rx_stall = 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			sb.check_word(out_sensor, median_angle, speed_rpm);
			words_taken++;
			@(negedge clk);
		end
	end

	// hold the output side off while samples keep coming
	initial begin
		wait (samples_sent >= 120);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
rtl/core/amse_pkg.sv
rtl/core/amse_ram.sv
rtl/core/amse_ctrl.sv
rtl/core/amse_dp.sv
rtl/core/angle_median_speed_estimator.sv
verif/tb_angle_median_speed_estimator.sv
